FILE: hw/rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared types and constants for the LIFO stack with peek.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int DATA_W     = 32;
  localparam int DEPTH_DEF  = 32;
  localparam int CAP_W      = 6;
  localparam int POS_W      = 6;
  localparam int REQ_W      = 3;
  localparam int STAT_W     = 2;
  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 3'd0,
    REQ_POP    = 3'd1,
    REQ_TOP    = 3'd2,
    REQ_BOTTOM = 3'd3,
    REQ_POS    = 3'd4
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage

FILE: hw/rtl/lsp_cell.sv
// ----------------------------------------------------------------------------
// lsp_cell
// One stack cell: shifts down on push, up on pop, drives its word when selected.
// ----------------------------------------------------------------------------
module lsp_cell import lsp_pkg::*; (
  input  logic                     clk,
  input  shift_ctl_t               ctl,
  input  logic signed [DATA_W-1:0] from_above,
  input  logic signed [DATA_W-1:0] from_below,
  input  logic                     sel,
  output logic signed [DATA_W-1:0] word,
  output logic signed [DATA_W-1:0] sel_word
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      word <= from_above;
    end else if (ctl.pop) begin
      word <= from_below;
    end
  end

  assign sel_word = sel ? word : '0;

endmodule

FILE: hw/rtl/lifo_stack_with_peek.sv
// The result is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while the result is not stalled; the cell row shifts in the same cycle.
// A stalled result holds off new requests until it is taken.
// Reset (rst, synchronous): count cleared, capacity set to 32, output idle.
// Cell contents are not reset.
// ----------------------------------------------------------------------------
// lifo_stack_with_peek
// Bounded LIFO of signed words held in a shifting row of cells, with reads of
// top, bottom or any position from the top.
// ----------------------------------------------------------------------------
module lifo_stack_with_peek import lsp_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [CAP_W-1:0]         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [REQ_W-1:0]         req_type,
  input  logic signed [DATA_W-1:0] push_value,
  input  logic [POS_W-1:0]         position,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] read_data,
  output logic [STAT_W-1:0]        status,
  output logic                     is_empty,
  output logic                     is_full
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);
  localparam int W  = (CW > CAP_W) ? CW : CAP_W;

  logic [CAP_W-1:0] capacity;
  logic [CW-1:0]    count;
  logic [CW-1:0]    count_next;

  logic [W-1:0]  count_w;
  logic [W-1:0]  cap_w;
  logic [W-1:0]  cap_eff;
  logic [W-1:0]  pos_w;
  logic [W-1:0]  pos_m1;
  logic [CW-1:0] count_m1;
  logic [IW-1:0] sel_idx;
  logic          empty;
  logic          full;
  logic          accept;
  req_t          kind;
  shift_ctl_t    ctl;

  logic signed [DATA_W-1:0] cell_word [DEPTH];
  logic signed [DATA_W-1:0] cell_sel  [DEPTH];
  logic signed [DATA_W-1:0] sel_data;

  logic signed [DATA_W-1:0] data_d;
  status_t                  stat_d;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;
  assign kind     = req_t'(req_type);

  assign count_w  = W'(count);
  assign cap_w    = W'(capacity);
  assign pos_w    = W'(position);
  assign pos_m1   = pos_w - W'(1);
  assign count_m1 = count - CW'(1);

  always_comb begin
    if (cap_w == '0) begin
      cap_eff = W'(1);
    end else if (cap_w > W'(DEPTH)) begin
      cap_eff = W'(DEPTH);
    end else begin
      cap_eff = cap_w;
    end
  end

  assign empty = (count == '0);
  assign full  = (count_w >= cap_eff);

  assign sel_idx = (kind == REQ_BOTTOM) ? count_m1[IW-1:0] : pos_m1[IW-1:0];

  assign ctl.push = accept && (kind == REQ_PUSH) && !full;
  assign ctl.pop  = accept && (kind == REQ_POP) && !empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] above;
    logic signed [DATA_W-1:0] below;
    if (i == 0) begin : g_top
      assign above = push_value;
    end else begin : g_mid
      assign above = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_word[i+1];
    end
    lsp_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .from_above (above),
      .from_below (below),
      .sel        (sel_idx == IW'(i)),
      .word       (cell_word[i]),
      .sel_word   (cell_sel[i])
    );
  end

  always_comb begin
    sel_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_data = sel_data | cell_sel[i];
    end
  end

  always_comb begin
    data_d = '0;
    stat_d = ST_OK;
    unique case (kind)
      REQ_PUSH: begin
        if (full) begin
          stat_d = ST_FULL;
        end
      end
      REQ_POP, REQ_TOP: begin
        if (empty) begin
          stat_d = ST_EMPTY;
        end else begin
          data_d = cell_word[0];
        end
      end
      REQ_BOTTOM: begin
        if (empty) begin
          stat_d = ST_EMPTY;
        end else begin
          data_d = sel_data;
        end
      end
      REQ_POS: begin
        if (empty) begin
          stat_d = ST_EMPTY;
        end else if (pos_w == '0 || pos_w > count_w) begin
          stat_d = ST_BADPOS;
        end else begin
          data_d = sel_data;
        end
      end
      default: begin
        data_d = '0;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + CW'(1);
    end else if (ctl.pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (!out_valid || !out_stall) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= data_d;
      status    <= stat_d;
      is_empty  <= (count_next == '0);
      is_full   <= (W'(count_next) >= cap_eff);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    W'(count) <= W'(DEPTH))
    else $error("entry count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> count == CW'($past(count) + CW'(1)))
    else $error("push did not grow the stack");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> read_data == '0)
    else $error("non-ok result carries data");

  a_accept_valid: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted request gave no result");

endmodule
